[src/cds_pkg.sv]
// cds_pkg: shared types, constants and date functions for the calendar date stepper
// used by cds_limits and calendar_date_stepper_top; depends on nothing else
`default_nettype none

package cds_pkg;

    localparam int DATE_W       = 25;
    localparam int REG_COUNT    = 4;
    localparam int CFG_IDX_W    = $clog2(REG_COUNT);
    localparam int YEAR_MIN     = 1900;
    localparam int YEAR_MAX     = 2099;
    localparam int MONTH_MAX    = 12;
    localparam int YEAR_SCALE   = 10000;
    localparam int MONTH_SCALE  = 100;
    localparam int CENTURY_BASE = 1800;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DATE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DATE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_START = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_END   = CFG_IDX_W'(3);

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [2:0] KEY_LEFT      = 3'd0;
    localparam logic [2:0] KEY_RIGHT     = 3'd1;
    localparam logic [2:0] KEY_UP        = 3'd2;
    localparam logic [2:0] KEY_DOWN      = 3'd3;
    localparam logic [2:0] KEY_PAGE_UP   = 3'd4;
    localparam logic [2:0] KEY_PAGE_DOWN = 3'd5;
    localparam logic [2:0] KEY_HOME      = 3'd6;
    localparam logic [2:0] KEY_END       = 3'd7;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  key;
        logic [13:0] set_year;
        logic [6:0]  set_month;
        logic [6:0]  set_day;
    } in_item_t;

    typedef struct packed {
        logic [DATE_W-1:0] date_value;
        logic [2:0]        weekday;
        logic              notify;
    } out_item_t;

    // digits of a packed value, not yet clamped
    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
    } raw_date_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef struct packed {
        logic      lo_en;
        logic      hi_en;
        logic      view_en;
        raw_date_t lo_raw;
        raw_date_t hi_raw;
        raw_date_t vs_raw;
        raw_date_t ve_raw;
        date_t     lo_cl;
        date_t     hi_cl;
    } limits_t;

    // good for the years one step can reach around the supported range
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != 12'(YEAR_MIN)) && (year != 12'(YEAR_MAX + 1));
    endfunction

    function automatic logic [4:0] month_days(input logic [11:0] year, input logic [3:0] month);
        logic [4:0] days;
        case (month) inside
            4'd2:                                     days = is_leap(year) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                  days = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            default:                                  days = 5'd30;
        endcase
        return days;
    endfunction

    function automatic raw_date_t mk_raw(input logic [11:0] year, input logic [3:0] month,
                                         input logic [4:0] day);
        raw_date_t r;
        r.year  = {2'b00, year};
        r.month = {3'b000, month};
        r.day   = {2'b00, day};
        return r;
    endfunction

    function automatic date_t clamp_date(input raw_date_t r);
        date_t      c;
        logic [4:0] md;
        if (r.year < 14'(YEAR_MIN))
        begin
            c.year = 12'(YEAR_MIN);
        end
        else if (r.year > 14'(YEAR_MAX))
        begin
            c.year = 12'(YEAR_MAX);
        end
        else
        begin
            c.year = r.year[11:0];
        end
        if (r.month == 7'd0)
        begin
            c.month = 4'd1;
        end
        else if (r.month > 7'(MONTH_MAX))
        begin
            c.month = 4'(MONTH_MAX);
        end
        else
        begin
            c.month = r.month[3:0];
        end
        md = month_days(c.year, c.month);
        if (r.day == 7'd0)
        begin
            c.day = 5'd1;
        end
        else if (r.day > {2'b00, md})
        begin
            c.day = md;
        end
        else
        begin
            c.day = r.day[4:0];
        end
        return c;
    endfunction

    // digit order matches numeric order of the packed value
    function automatic logic raw_lt(input raw_date_t a, input raw_date_t b);
        logic lt;
        if (a.year != b.year)
        begin
            lt = a.year < b.year;
        end
        else if (a.month != b.month)
        begin
            lt = a.month < b.month;
        end
        else
        begin
            lt = a.day < b.day;
        end
        return lt;
    endfunction

    function automatic date_t apply_limits(input date_t c, input limits_t l);
        date_t     r;
        raw_date_t v;
        r = c;
        v = mk_raw(c.year, c.month, c.day);
        if (l.lo_en && raw_lt(v, l.lo_raw))
        begin
            r = l.lo_cl;
        end
        if (l.hi_en && raw_lt(l.hi_raw, v))
        begin
            r = l.hi_cl;
        end
        return r;
    endfunction

    function automatic logic [DATE_W-1:0] pack_date(input date_t c);
        return DATE_W'(c.year) * DATE_W'(YEAR_SCALE) + DATE_W'(c.month) * DATE_W'(MONTH_SCALE)
             + DATE_W'(c.day);
    endfunction

    function automatic logic [2:0] mod7(input logic [7:0] s);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(s[7:6]) + 5'(s[5:3]) + 5'(s[2:0]);
        b = 4'(a[4:3]) + 4'(a[2:0]);
        if (b >= 4'd7)
        begin
            b = b - 4'd7;
        end
        return b[2:0];
    endfunction

    function automatic logic [2:0] weekday_of(input date_t c);
        logic [8:0] n;
        logic [3:0] mz;
        logic [6:0] k;
        logic [5:0] mt;
        logic [2:0] cj;
        logic [7:0] sum;
        if (c.month < 4'd3)
        begin
            n  = 9'(c.year - 12'(CENTURY_BASE + 1));
            mz = c.month + 4'd12;
        end
        else
        begin
            n  = 9'(c.year - 12'(CENTURY_BASE));
            mz = c.month;
        end
        // century terms j/4 + 5j + 6 folded mod 7
        if (n >= 9'd200)
        begin
            k  = 7'(n - 9'd200);
            cj = 3'd6;
        end
        else if (n >= 9'd100)
        begin
            k  = 7'(n - 9'd100);
            cj = 3'd0;
        end
        else
        begin
            k  = n[6:0];
            cj = 3'd2;
        end
        // 13 * (m + 1) / 5
        case (mz)
            4'd3:    mt = 6'd10;
            4'd4:    mt = 6'd13;
            4'd5:    mt = 6'd15;
            4'd6:    mt = 6'd18;
            4'd7:    mt = 6'd20;
            4'd8:    mt = 6'd23;
            4'd9:    mt = 6'd26;
            4'd10:   mt = 6'd28;
            4'd11:   mt = 6'd31;
            4'd12:   mt = 6'd33;
            4'd13:   mt = 6'd36;
            4'd14:   mt = 6'd39;
            default: mt = 6'd0;
        endcase
        sum = 8'(c.day) + 8'(mt) + 8'(k) + 8'(k[6:2]) + 8'(cj);
        return mod7(sum);
    endfunction

endpackage

`default_nettype wire

[src/cds_limits.sv]
// cds_limits: configuration registers, digit split of each written value and the
// limit set used by the stepper; depends on cds_pkg
`default_nettype none

module cds_limits (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cds_pkg::DATE_W-1:0]     cfg_data,
    output cds_pkg::limits_t                    lim
);
    import cds_pkg::*;

    localparam int SHIFT_Y = 28;
    localparam int SHIFT_M = 20;
    localparam int RECIP_Y = (1 << SHIFT_Y) / YEAR_SCALE;
    localparam int RECIP_M = (1 << SHIFT_M) / MONTH_SCALE;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_QUOT   = 3'd1;
    localparam logic [2:0] PH_YFIX   = 3'd2;
    localparam logic [2:0] PH_MON    = 3'd3;
    localparam logic [2:0] PH_MFIX   = 3'd4;
    localparam logic [2:0] PH_SETTLE = 3'd5;

    logic [2:0]           phase_reg;
    logic [2:0]           phase_next;
    logic [DATE_W-1:0]    value_reg;
    logic [CFG_IDX_W-1:0] idx_reg;
    logic [11:0]          quot_reg;
    logic [13:0]          rem_reg;
    logic [6:0]           mon_reg;
    raw_date_t            store_reg [REG_COUNT];
    limits_t              lim_reg;
    limits_t              lim_next;

    logic [39:0]          prod_y;
    logic [27:0]          prod_m;
    logic [DATE_W-1:0]    rem_full;
    logic [7:0]           day_full;

    assign cfg_ready = (phase_reg == PH_IDLE);
    assign lim       = lim_reg;

    assign prod_y   = 40'(value_reg) * 40'(RECIP_Y);
    assign prod_m   = 28'(rem_reg) * 28'(RECIP_M);
    assign rem_full = value_reg - DATE_W'(quot_reg) * DATE_W'(YEAR_SCALE);
    assign day_full = 8'(rem_reg - 14'(mon_reg) * 14'(MONTH_SCALE));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:   if (cfg_valid) phase_next = PH_QUOT;
            PH_QUOT:   phase_next = PH_YFIX;
            PH_YFIX:   phase_next = PH_MON;
            PH_MON:    phase_next = PH_MFIX;
            PH_MFIX:   phase_next = PH_SETTLE;
            PH_SETTLE: phase_next = PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // digit split: reciprocal estimate in PH_QUOT / PH_MON, single correction in PH_YFIX / PH_MFIX
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && cfg_valid)
        begin
            value_reg <= cfg_data;
            idx_reg   <= cfg_index;
        end
        if (phase_reg == PH_QUOT)
        begin
            quot_reg <= 12'(prod_y >> SHIFT_Y);
        end
        if (phase_reg == PH_YFIX)
        begin
            if (rem_full >= DATE_W'(YEAR_SCALE))
            begin
                quot_reg <= quot_reg + 12'd1;
                rem_reg  <= 14'(rem_full - DATE_W'(YEAR_SCALE));
            end
            else
            begin
                rem_reg <= 14'(rem_full);
            end
        end
        if (phase_reg == PH_MON)
        begin
            mon_reg <= 7'(prod_m >> SHIFT_M);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (phase_reg == PH_MFIX)
        begin
            if (day_full >= 8'(MONTH_SCALE))
            begin
                store_reg[idx_reg].year  <= {2'b00, quot_reg};
                store_reg[idx_reg].month <= mon_reg + 7'd1;
                store_reg[idx_reg].day   <= 7'(day_full - 8'(MONTH_SCALE));
            end
            else
            begin
                store_reg[idx_reg].year  <= {2'b00, quot_reg};
                store_reg[idx_reg].month <= mon_reg;
                store_reg[idx_reg].day   <= day_full[6:0];
            end
        end
    end

    always_comb
    begin
        raw_date_t mn;
        raw_date_t mx;
        raw_date_t vs;
        raw_date_t ve;
        logic      swap;
        mn = store_reg[REG_MIN_DATE];
        mx = store_reg[REG_MAX_DATE];
        vs = store_reg[REG_VIEW_START];
        ve = store_reg[REG_VIEW_END];
        lim_next.lo_en   = |mn;
        lim_next.hi_en   = |mx;
        swap             = (|mn) && (|mx) && raw_lt(mx, mn);
        lim_next.lo_raw  = swap ? mx : mn;
        lim_next.hi_raw  = swap ? mn : mx;
        lim_next.lo_cl   = clamp_date(lim_next.lo_raw);
        lim_next.hi_cl   = clamp_date(lim_next.hi_raw);
        lim_next.view_en = (|vs) && (|ve);
        lim_next.vs_raw  = raw_lt(ve, vs) ? ve : vs;
        lim_next.ve_raw  = raw_lt(ve, vs) ? vs : ve;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= '0;
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

endmodule

`default_nettype wire

[src/calendar_date_stepper_top.sv]
// calendar_date_stepper_top: date register, next-date logic and result register
// depends on cds_pkg and cds_limits
`default_nettype none

// One result per item, one item per clock sustained while result_ready is high and no
// configuration write is in progress: an accepted beat is held in the item register,
// and the next date, chosen by short compare-and-select logic that reads the date
// register directly, is written at once into the date register and the result
// register, so the following item already sees the new date. The date and weekday
// on the result port are formed from the result register by constant multiplies and
// a small mod-7 fold.
// A configuration write splits the value into year, month and day with reciprocal
// multiplies in PH_QUOT, PH_YFIX, PH_MON and PH_MFIX, then PH_SETTLE; cfg_ready and
// item_ready stay low through all of them. No clearing pass after reset.
module calendar_date_stepper_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire cds_pkg::in_item_t              item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output cds_pkg::out_item_t                  result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cds_pkg::DATE_W-1:0]     cfg_data
);
    import cds_pkg::*;

    limits_t   lim;
    in_item_t  item_reg;
    logic      item_valid_reg;
    date_t     cur_reg;
    date_t     cur_next;
    date_t     out_date_reg;
    logic      out_notify_reg;
    logic      out_valid_reg;
    logic      notify_next;
    logic      advance;

    cds_limits u_limits (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lim       (lim)
    );

    assign advance    = item_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = cfg_ready && (!item_valid_reg || advance);

    assign result_valid      = out_valid_reg;
    assign result.date_value = pack_date(out_date_reg);
    assign result.weekday    = weekday_of(out_date_reg);
    assign result.notify     = out_notify_reg;

    always_comb
    begin
        logic [4:0] cur_md;
        logic [4:0] prev_md;
        logic [11:0] prev_year;
        logic [3:0]  prev_month;
        logic [11:0] fwd_year;
        logic [3:0]  fwd_month;
        logic [5:0]  day6;
        logic [5:0]  tmp6;
        raw_date_t   target;
        raw_date_t   set_raw;
        logic        target_ok;

        cur_md = month_days(cur_reg.year, cur_reg.month);
        if (cur_reg.month == 4'd1)
        begin
            prev_month = 4'(MONTH_MAX);
            prev_year  = cur_reg.year - 12'd1;
        end
        else
        begin
            prev_month = cur_reg.month - 4'd1;
            prev_year  = cur_reg.year;
        end
        if (cur_reg.month == 4'(MONTH_MAX))
        begin
            fwd_month = 4'd1;
            fwd_year  = cur_reg.year + 12'd1;
        end
        else
        begin
            fwd_month = cur_reg.month + 4'd1;
            fwd_year  = cur_reg.year;
        end
        prev_md = month_days(prev_year, prev_month);
        day6    = {1'b0, cur_reg.day};
        tmp6    = '0;

        unique case (item_reg.key)
            KEY_LEFT:
            begin
                if (cur_reg.day == 5'd1)
                begin
                    target = mk_raw(prev_year, prev_month, prev_md);
                end
                else
                begin
                    target = mk_raw(cur_reg.year, cur_reg.month, cur_reg.day - 5'd1);
                end
            end
            KEY_RIGHT:
            begin
                if (cur_reg.day == cur_md)
                begin
                    target = mk_raw(fwd_year, fwd_month, 5'd1);
                end
                else
                begin
                    target = mk_raw(cur_reg.year, cur_reg.month, cur_reg.day + 5'd1);
                end
            end
            KEY_UP:
            begin
                if (cur_reg.day <= 5'd7)
                begin
                    tmp6   = day6 + {1'b0, prev_md} - 6'd7;
                    target = mk_raw(prev_year, prev_month, tmp6[4:0]);
                end
                else
                begin
                    target = mk_raw(cur_reg.year, cur_reg.month, cur_reg.day - 5'd7);
                end
            end
            KEY_DOWN:
            begin
                tmp6 = day6 + 6'd7;
                if (tmp6 > {1'b0, cur_md})
                begin
                    tmp6   = tmp6 - {1'b0, cur_md};
                    target = mk_raw(fwd_year, fwd_month, tmp6[4:0]);
                end
                else
                begin
                    target = mk_raw(cur_reg.year, cur_reg.month, tmp6[4:0]);
                end
            end
            KEY_HOME:
            begin
                target = lim.view_en ? lim.vs_raw : mk_raw(cur_reg.year, cur_reg.month, 5'd1);
            end
            default:
            begin
                target = lim.view_en ? lim.ve_raw : mk_raw(cur_reg.year, cur_reg.month, cur_md);
            end
        endcase

        target_ok = !(lim.lo_en && raw_lt(target, lim.lo_raw))
                 && !(lim.hi_en && raw_lt(lim.hi_raw, target))
                 && !(lim.view_en && (raw_lt(target, lim.vs_raw) || raw_lt(lim.ve_raw, target)));

        set_raw.year  = item_reg.set_year;
        set_raw.month = item_reg.set_month;
        set_raw.day   = item_reg.set_day;

        cur_next    = cur_reg;
        notify_next = 1'b0;
        if (item_reg.cmd == CMD_LOAD)
        begin
            cur_next = apply_limits(clamp_date(set_raw), lim);
        end
        else if (item_reg.key == KEY_PAGE_UP)
        begin
            if (!lim.view_en)
            begin
                cur_next = apply_limits(clamp_date(mk_raw(prev_year, prev_month, cur_reg.day)),
                                        lim);
            end
        end
        else if (item_reg.key == KEY_PAGE_DOWN)
        begin
            if (!lim.view_en)
            begin
                cur_next = apply_limits(clamp_date(mk_raw(fwd_year, fwd_month, cur_reg.day)),
                                        lim);
            end
        end
        else if (target_ok)
        begin
            cur_next    = apply_limits(clamp_date(target), lim);
            notify_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg.year   <= 12'(YEAR_MIN);
            cur_reg.month  <= 4'd1;
            cur_reg.day    <= 5'd1;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            out_date_reg   <= cur_next;
            out_notify_reg <= notify_next;
        end
    end

    a_cfg_holds_items: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> !item_ready)
        else $error("item taken while configuration is being split");

    a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg.year >= 12'(YEAR_MIN) && cur_reg.year <= 12'(YEAR_MAX)
        && cur_reg.month >= 4'd1 && cur_reg.month <= 4'(MONTH_MAX)
        && cur_reg.day >= 5'd1 && cur_reg.day <= month_days(cur_reg.year, cur_reg.month))
        else $error("current date out of range");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.cmd == CMD_LOAD |=> !out_notify_reg)
        else $error("date load raised notify");

    a_stall_holds_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ready |=> $stable(cur_reg))
        else $error("date moved while result stalled");

endmodule

`default_nettype wire
